[rtl/core/ptt_pkg.sv]
// Package for the periodic timer table: sizes, request and result codes,
// and the command record that travels from the front end to the back end.
// No dependencies.
package ptt_pkg;

  localparam int DEPTH    = 16;
  localparam int ID_WIDTH = 16;

  // The request carries a 16-bit id, so no more than 16 bits are ever kept.
  localparam int ID_W  = (ID_WIDTH < 16) ? ID_WIDTH : 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam logic [1:0] REQ_ADD  = 2'd0;
  localparam logic [1:0] REQ_DEL  = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_ZERO,
    OP_DEL,
    OP_TICK
  } op_t;

  typedef enum logic [2:0] {
    K_ADDED    = 3'd0,
    K_FULL     = 3'd1,
    K_ZERO     = 3'd2,
    K_DELETED  = 3'd3,
    K_NOTFOUND = 3'd4,
    K_FIRED    = 3'd5,
    K_DONE     = 3'd6
  } kind_t;

  typedef struct packed {
    op_t              op;
    logic [ID_W-1:0]  timer_id;
    logic [31:0]      period_ms;
    logic [31:0]      user_param;
    logic             repeat_req;
    logic [31:0]      now_ms;
  } cmd_t;

  typedef struct packed {
    kind_t        kind;
    logic [15:0]  fired_id;
    logic [31:0]  fired_param;
    logic         last;
  } result_t;

endpackage

[rtl/core/periodic_timer_table.sv]
// Periodic timer table top level: front end, command queue and back end.
// Depends on ptt_pkg, ptt_front, ptt_queue and ptt_back.
//
// Requests (add, delete, tick) enter on the slave stream and land in a
// two-entry command queue; the back end walks the slot table one slot per
// clock cycle, but a tick holds at a due slot while a fired result waits
// on the master side. Add and delete stop at the first free or matching
// slot, and an add with a zero period goes to its result without a walk.
// A tick returns one fired result per due slot in slot order, then a
// tick-done result with tlast set; every other request returns one result
// with tlast set. Request code 3 is accepted and dropped. The result
// register lets the back end keep walking while a result waits, up to the
// next due slot of a tick, and the queue lets new requests come in during
// a walk.
module periodic_timer_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [119:0]  s_tdata,   // timer_id[15:0], period_ms[47:16], user_param[79:48],
                                   // repeat_req[80], now_ms[112:81], zero fill above
  input  logic [1:0]    s_tuser,   // req_type
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [47:0]   m_tdata,   // fired_id[15:0], fired_param[47:16]
  output logic [2:0]    m_tuser,   // kind
  output logic          m_tlast
);

  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  ptt_pkg::cmd_t     push_cmd;
  ptt_pkg::cmd_t     head_cmd;
  ptt_pkg::result_t  res;

  ptt_front u_front (
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  ptt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  ptt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (head_cmd),
    .q_pop   (q_pop),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_res   (res)
  );

  assign m_tdata = {res.fired_param, res.fired_id};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

endmodule

[rtl/core/ptt_front.sv]
// Front end of the periodic timer table: accepts request transactions,
// sorts them into commands and drops unused request codes.
// Depends on ptt_pkg.
module ptt_front (
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [119:0]        s_tdata,   // timer_id, period_ms, user_param, repeat_req, now_ms
  input  logic [1:0]          s_tuser,   // req_type
  input  logic                q_full,
  output logic                q_push,
  output ptt_pkg::cmd_t       q_cmd
);

  logic        accept;
  logic        known;
  logic [31:0] period;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign period   = s_tdata[47:16];

  always_comb begin
    known         = 1'b1;
    q_cmd.op      = ptt_pkg::OP_TICK;
    q_cmd.timer_id   = s_tdata[ptt_pkg::ID_W-1:0];
    q_cmd.period_ms  = period;
    q_cmd.user_param = s_tdata[79:48];
    q_cmd.repeat_req = s_tdata[80];
    q_cmd.now_ms     = s_tdata[112:81];
    case (s_tuser)
      ptt_pkg::REQ_ADD: begin
        q_cmd.op = (period == 32'd0) ? ptt_pkg::OP_ZERO : ptt_pkg::OP_ADD;
      end
      ptt_pkg::REQ_DEL: begin
        q_cmd.op = ptt_pkg::OP_DEL;
      end
      ptt_pkg::REQ_TICK: begin
        q_cmd.op = ptt_pkg::OP_TICK;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // An unused request code is taken and produces nothing.
  assign q_push = accept && known && !rst;

endmodule

[rtl/core/ptt_queue.sv]
// Short command queue between the front and back ends of the timer table.
// Depends on ptt_pkg.
module ptt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ptt_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output ptt_pkg::cmd_t  head_cmd
);

  ptt_pkg::cmd_t                entry [ptt_pkg::QDEPTH];
  logic [ptt_pkg::QPTR_W-1:0]   wr_ptr;
  logic [ptt_pkg::QPTR_W-1:0]   rd_ptr;
  logic [ptt_pkg::QCNT_W-1:0]   count;
  logic                         do_push;
  logic                         do_pop;

  assign full       = count == ptt_pkg::QCNT_W'(ptt_pkg::QDEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = entry[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  function automatic logic [ptt_pkg::QPTR_W-1:0] bump(input logic [ptt_pkg::QPTR_W-1:0] p);
    bump = (p == ptt_pkg::QPTR_W'(ptt_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

endmodule

[rtl/core/ptt_back.sv]
// Back end of the timer table: holds the slots and walks them one per cycle
// for add, delete and tick commands, driving the result register; a tick
// waits at a due slot while a result is stalled. Depends on ptt_pkg.
module ptt_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  ptt_pkg::cmd_t     q_cmd,
  output logic              q_pop,
  output logic              m_valid,
  input  logic              m_ready,
  output ptt_pkg::result_t  m_res
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t                      state;
  ptt_pkg::cmd_t               cmd;
  ptt_pkg::kind_t              fin_kind;
  logic [ptt_pkg::IDX_W-1:0]   idx;
  logic [ptt_pkg::DEPTH-1:0]   slot_used;

  logic [ptt_pkg::ID_W-1:0]    slot_id        [ptt_pkg::DEPTH];
  logic [31:0]                 slot_period    [ptt_pkg::DEPTH];
  logic [31:0]                 slot_last_fire [ptt_pkg::DEPTH];
  logic [31:0]                 slot_param     [ptt_pkg::DEPTH];
  logic                        slot_repeat    [ptt_pkg::DEPTH];

  logic        out_free;
  logic        at_end;
  logic        used_here;
  logic        due;
  logic [31:0] elapsed;
  logic        wr_add;
  logic        del_hit;
  logic        fire;
  logic        tick_wait;
  logic        res_load;

  assign out_free  = !m_valid || m_ready;
  assign at_end    = idx == ptt_pkg::IDX_W'(ptt_pkg::DEPTH - 1);
  assign used_here = slot_used[idx];
  assign elapsed   = cmd.now_ms - slot_last_fire[idx];
  assign due       = used_here && (elapsed >= slot_period[idx]);
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign res_load  = fire || ((state == S_FINISH) && out_free);

  always_comb begin
    wr_add    = 1'b0;
    del_hit   = 1'b0;
    fire      = 1'b0;
    tick_wait = 1'b0;
    if (state == S_SCAN) begin
      case (cmd.op)
        ptt_pkg::OP_ADD:  wr_add  = !used_here;
        ptt_pkg::OP_DEL:  del_hit = used_here && (slot_id[idx] == cmd.timer_id);
        ptt_pkg::OP_TICK: begin
          fire      = due && out_free;
          tick_wait = due && !out_free;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      m_valid   <= 1'b0;
      idx       <= '0;
      slot_used <= '0;
    end else begin
      if (res_load) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cmd <= q_cmd;
            idx <= '0;
            if (q_cmd.op == ptt_pkg::OP_ZERO) begin
              fin_kind <= ptt_pkg::K_ZERO;
              state    <= S_FINISH;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          case (cmd.op)
            ptt_pkg::OP_ADD: begin
              if (wr_add) begin
                slot_used[idx] <= 1'b1;
                fin_kind       <= ptt_pkg::K_ADDED;
                state          <= S_FINISH;
              end else if (at_end) begin
                fin_kind <= ptt_pkg::K_FULL;
                state    <= S_FINISH;
              end else begin
                idx <= idx + 1'b1;
              end
            end
            ptt_pkg::OP_DEL: begin
              if (del_hit) begin
                slot_used[idx] <= 1'b0;
                fin_kind       <= ptt_pkg::K_DELETED;
                state          <= S_FINISH;
              end else if (at_end) begin
                fin_kind <= ptt_pkg::K_NOTFOUND;
                state    <= S_FINISH;
              end else begin
                idx <= idx + 1'b1;
              end
            end
            default: begin
              // A due slot holds the walk until the result register frees up.
              if (fire) begin
                m_res.kind        <= ptt_pkg::K_FIRED;
                m_res.fired_id    <= 16'(slot_id[idx]);
                m_res.fired_param <= slot_param[idx];
                m_res.last        <= 1'b0;
                if (!slot_repeat[idx]) begin
                  slot_used[idx] <= 1'b0;
                end
              end
              if (!tick_wait) begin
                if (at_end) begin
                  fin_kind <= ptt_pkg::K_DONE;
                  state    <= S_FINISH;
                end else begin
                  idx <= idx + 1'b1;
                end
              end
            end
          endcase
        end
        S_FINISH: begin
          if (out_free) begin
            m_res.kind        <= fin_kind;
            m_res.fired_id    <= '0;
            m_res.fired_param <= '0;
            m_res.last        <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_add) begin
      slot_id[idx]        <= cmd.timer_id;
      slot_period[idx]    <= cmd.period_ms;
      slot_last_fire[idx] <= cmd.now_ms;
      slot_param[idx]     <= cmd.user_param;
      slot_repeat[idx]    <= cmd.repeat_req;
    end else if (fire) begin
      slot_last_fire[idx] <= cmd.now_ms;
    end
  end

endmodule

[rtl/core/ptt_checker.sv]
// Port-level checks for the periodic timer table, bound to the top level.
// Depends on ptt_pkg and periodic_timer_table.
module ptt_checker (
  input logic          clk,
  input logic          rst,
  input logic          s_tvalid,
  input logic          s_tready,
  input logic [119:0]  s_tdata,
  input logic [1:0]    s_tuser,
  input logic          m_tvalid,
  input logic          m_tready,
  input logic [47:0]   m_tdata,
  input logic [2:0]    m_tuser,
  input logic          m_tlast
);

  logic is_fired;

  assign is_fired = m_tuser == 3'(ptt_pkg::K_FIRED);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  a_fired_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && is_fired |-> !m_tlast)
    else $error("fired result marked as last");

  a_other_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !is_fired |-> m_tlast && (m_tdata == 48'd0))
    else $error("non-fired result must be last with zero data");

  a_fired_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && is_fired |=> !(m_tvalid && m_tlast &&
      m_tuser != 3'(ptt_pkg::K_DONE)))
    else $error("fired results must end in tick done");

endmodule

bind periodic_timer_table ptt_checker u_ptt_checker (.*);
